// ===== rtl/core/tdq_pkg.sv =====
// shared types and constants of the timer deadline queue
package tdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK       = 2'd0,
    KIND_EXPIRED   = 2'd1,
    KIND_TICK_DONE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] deadline;
    logic        wrap;
    logic [7:0]  task_tag;
    logic [15:0] group_tag;
  } entry_t;

  typedef enum logic [2:0] {
    DP_NOP      = 3'd0,
    DP_INSERT   = 3'd1,
    DP_CLEAR    = 3'd2,
    DP_CAN_STEP = 3'd3,
    DP_POP      = 3'd4,
    DP_FIX      = 3'd5,
    DP_ACK      = 3'd6,
    DP_TICK_FIN = 3'd7
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   set_prev;
    logic   clr_scan;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_live;
    logic scan_match;
    logic head_live;
    logic head_due;
    logic time_back;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/tdq_if.sv =====
// handshake channels of the timer deadline queue
interface tdq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] deadline;
  logic        past_wrap;
  logic [7:0]  task_tag;
  logic [15:0] group_tag;
  logic [31:0] now_time;
  modport source (output valid, cmd, deadline, past_wrap, task_tag, group_tag, now_time,
                  input ready);
  modport sink (input valid, cmd, deadline, past_wrap, task_tag, group_tag, now_time,
                output ready);
endinterface

interface tdq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        status;
  logic [7:0]  expired_task;
  logic [15:0] expired_group;
  logic [31:0] wait_time;
  logic [4:0]  occupancy;
  logic        last;
  modport source (output valid, kind, status, expired_task, expired_group, wait_time,
                  occupancy, last, input ready);
  modport sink (input valid, kind, status, expired_task, expired_group, wait_time,
                occupancy, last, output ready);
endinterface

// ===== rtl/core/tdq_datapath.sv =====
// sorted entry array, scan counter, time registers and output word register
module tdq_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             latch_i,
  input  logic [31:0]      deadline_i,
  input  logic             past_wrap_i,
  input  logic [7:0]       task_tag_i,
  input  logic [15:0]      group_tag_i,
  input  logic [31:0]      now_time_i,
  input  tdq_pkg::dp_cmd_t cmd_i,
  output tdq_pkg::dp_sts_t sts_o,
  tdq_out_if.source        out_o
);
  import tdq_pkg::*;

  entry_t           entry_q [QUEUE_DEPTH];
  entry_t           entry_d [QUEUE_DEPTH];
  entry_t           prev_e  [QUEUE_DEPTH];
  entry_t           next_e  [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_q, count_d, scan_q, scan_d;
  logic [IDX_W-1:0] sidx;
  logic [31:0]      prev_time_q, prev_time_d, now_q;
  entry_t           key_q, fix_e, ins_e;
  logic [QUEUE_DEPTH-1:0] lt;
  logic [CNT_W-1:0] limit, rm_at;

  logic             ov_q, ov_d;
  logic [1:0]       kind_q, kind_d;
  logic             status_q, status_d, last_q, last_d;
  logic [7:0]       task_q, task_d;
  logic [15:0]      group_q, group_d;
  logic [31:0]      wait_q, wait_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic             emit, out_free, full, do_ins, do_rm;

  assign sidx     = scan_q[IDX_W-1:0];
  assign out_free = !ov_q || out_o.ready;
  assign full     = count_q >= CNT_W'(QUEUE_DEPTH);

  always_comb begin
    fix_e      = entry_q[sidx];
    fix_e.wrap = 1'b0;
  end

  // neighbors for one-place shifts up and down
  always_comb begin
    prev_e[0] = entry_q[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) prev_e[i] = entry_q[i-1];
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) next_e[i] = entry_q[i+1];
    next_e[QUEUE_DEPTH-1] = entry_q[QUEUE_DEPTH-1];
  end

  // entries that stay in front of the new one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd_i.op == DP_FIX) begin
        lt[i] = (CNT_W'(i) < scan_q) && (entry_q[i].deadline < fix_e.deadline);
      end else if (entry_q[i].wrap == key_q.wrap) begin
        lt[i] = (CNT_W'(i) < count_q) && (entry_q[i].deadline < key_q.deadline);
      end else begin
        lt[i] = (CNT_W'(i) < count_q) && key_q.wrap;
      end
    end
  end

  always_comb begin
    entry_d     = entry_q;
    count_d     = count_q;
    scan_d      = scan_q;
    prev_time_d = prev_time_q;
    emit        = 1'b0;
    do_ins      = 1'b0;
    do_rm       = 1'b0;
    rm_at       = '0;
    ins_e       = key_q;
    limit       = count_q + CNT_W'(1);
    kind_d      = KIND_ACK;
    status_d    = 1'b0;
    task_d      = '0;
    group_d     = '0;
    wait_d      = '0;
    occ_d       = count_q;
    last_d      = 1'b1;
    case (cmd_i.op)
      DP_INSERT: begin
        emit     = 1'b1;
        status_d = full;
        if (!full) begin
          do_ins  = 1'b1;
          count_d = count_q + CNT_W'(1);
          occ_d   = count_d;
        end
      end
      DP_CLEAR: begin
        emit    = 1'b1;
        count_d = '0;
        occ_d   = '0;
      end
      DP_CAN_STEP: begin
        if (entry_q[sidx].group_tag == key_q.group_tag) begin
          do_rm   = 1'b1;
          rm_at   = scan_q;
          count_d = count_q - CNT_W'(1);
        end else begin
          scan_d = scan_q + CNT_W'(1);
        end
      end
      DP_POP: begin
        emit    = 1'b1;
        do_rm   = 1'b1;
        count_d = count_q - CNT_W'(1);
        kind_d  = KIND_EXPIRED;
        task_d  = entry_q[0].task_tag;
        group_d = entry_q[0].group_tag;
        occ_d   = count_d;
        last_d  = 1'b0;
      end
      DP_FIX: begin
        do_ins = 1'b1;
        ins_e  = fix_e;
        limit  = scan_q + CNT_W'(1);
        scan_d = scan_q + CNT_W'(1);
      end
      DP_ACK: emit = 1'b1;
      DP_TICK_FIN: begin
        emit   = 1'b1;
        kind_d = KIND_TICK_DONE;
        wait_d = (count_q != '0) ? entry_q[0].deadline - now_q : 32'd0;
      end
      default: ;
    endcase
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_ins && (CNT_W'(i) < limit) && !lt[i]) begin
        if (i == 0) entry_d[i] = ins_e;
        else entry_d[i] = lt[(i == 0) ? 0 : i - 1] ? ins_e : prev_e[i];
      end
      if (do_rm && (CNT_W'(i) >= rm_at)) entry_d[i] = next_e[i];
    end
    if (cmd_i.set_prev) prev_time_d = now_q;
    if (cmd_i.clr_scan) scan_d = '0;
  end

  always_comb begin
    if (emit) ov_d = 1'b1;
    else if (out_o.ready) ov_d = 1'b0;
    else ov_d = ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= '0;
      prev_time_q <= '0;
      ov_q        <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_q      <= scan_d;
      prev_time_q <= prev_time_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (latch_i) begin
      key_q <= '{deadline: deadline_i, wrap: past_wrap_i, task_tag: task_tag_i,
                 group_tag: group_tag_i};
      now_q <= now_time_i;
    end
    if (emit) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      task_q   <= task_d;
      group_q  <= group_d;
      wait_q   <= wait_d;
      occ_q    <= occ_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.kind          = kind_q;
  assign out_o.status        = status_q;
  assign out_o.expired_task  = task_q;
  assign out_o.expired_group = group_q;
  assign out_o.wait_time     = wait_q;
  assign out_o.occupancy     = 5'(occ_q);
  assign out_o.last          = last_q;

  assign sts_o.full       = full;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.scan_live  = scan_q < count_q;
  assign sts_o.scan_match = entry_q[sidx].group_tag == key_q.group_tag;
  assign sts_o.head_live  = (count_q != '0) && !entry_q[0].wrap;
  assign sts_o.head_due   = entry_q[0].deadline <= now_q;
  assign sts_o.time_back  = prev_time_q > now_q;
  assign sts_o.out_free   = out_free;

endmodule

// ===== rtl/core/tdq_ctrl.sv =====
// command sequencer of the timer deadline queue
module tdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_cmd_i,
  output logic             in_ready_o,
  output logic             latch_o,
  input  tdq_pkg::dp_sts_t sts_i,
  output tdq_pkg::dp_cmd_t cmd_o
);
  import tdq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_INS  = 9'b000000010,
    S_CLR  = 9'b000000100,
    S_CAN  = 9'b000001000,
    S_TCHK = 9'b000010000,
    S_WEXP = 9'b000100000,
    S_WFIX = 9'b001000000,
    S_EXP  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign latch_o    = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = DP_NOP;
    cmd_o.set_prev = 1'b0;
    cmd_o.clr_scan = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (latch_o) begin
          cmd_o.clr_scan = 1'b1;
          case (cmd_e'(in_cmd_i))
            CMD_INSERT: state_d = S_INS;
            CMD_TICK:   state_d = S_TCHK;
            CMD_CANCEL: state_d = S_CAN;
            CMD_CLEAR:  state_d = S_CLR;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_INS: if (sts_i.out_free) begin
        cmd_o.op = DP_INSERT;
        state_d  = S_IDLE;
      end
      S_CLR: if (sts_i.out_free) begin
        cmd_o.op = DP_CLEAR;
        state_d  = S_IDLE;
      end
      S_CAN: begin
        if (sts_i.scan_live) begin
          cmd_o.op = DP_CAN_STEP;
        end else if (sts_i.out_free) begin
          cmd_o.op = DP_ACK;
          state_d  = S_IDLE;
        end
      end
      S_TCHK: begin
        if (sts_i.empty) begin
          state_d = S_FIN;
        end else begin
          cmd_o.set_prev = 1'b1;
          state_d        = sts_i.time_back ? S_WEXP : S_EXP;
        end
      end
      // time went backwards: unwrapped entries all sit in front
      S_WEXP: begin
        if (!sts_i.head_live) begin
          state_d = S_WFIX;
        end else if (sts_i.out_free) begin
          cmd_o.op = DP_POP;
        end
      end
      S_WFIX: begin
        if (sts_i.scan_live) cmd_o.op = DP_FIX;
        else state_d = S_EXP;
      end
      S_EXP: begin
        if (!(sts_i.head_live && sts_i.head_due)) begin
          state_d = S_FIN;
        end else if (sts_i.out_free) begin
          cmd_o.op = DP_POP;
        end
      end
      S_FIN: if (sts_i.out_free) begin
        cmd_o.op = DP_TICK_FIN;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

// ===== rtl/core/timer_deadline_queue_top.sv =====
// timer deadline queue: top level
// Keeps up to 16 timer entries sorted by wrap flag and deadline in flip-flops.
// One word is taken at a time. Insert and clear need no scan, and cancel scans
// the entries one by one. A tick on an empty queue only reports; otherwise it
// pops each expired entry, and after a backwards time step it first pops the
// unwrapped entries and re-sorts the wrapped ones; each step is a state of the
// sequencer over the shared entry array. A result word is held in an output
// register and the sequencer stalls while it is not taken.
module timer_deadline_queue_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdq_in_if.sink    in_i,
  tdq_out_if.source out_o
);
  import tdq_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    latch;
  logic    in_ready;

  assign in_i.ready = in_ready;

  tdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready),
    .latch_o    (latch),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  tdq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .latch_i     (latch),
    .deadline_i  (in_i.deadline),
    .past_wrap_i (in_i.past_wrap),
    .task_tag_i  (in_i.task_tag),
    .group_tag_i (in_i.group_tag),
    .now_time_i  (in_i.now_time),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/core/tdq_checker.sv =====
// port checks of the timer deadline queue and their binding
module tdq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [4:0] out_occ,
  input logic       out_last
);
  import tdq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_EXPIRED) |-> !out_last)
    else $error("expired entry marked last");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (32'(out_occ) <= QUEUE_DEPTH) &&
                  (out_kind == KIND_ACK || out_kind == KIND_EXPIRED ||
                   out_kind == KIND_TICK_DONE))
    else $error("bad occupancy or kind");

endmodule

bind timer_deadline_queue_top tdq_checker u_tdq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.kind),
  .out_occ   (out_o.occupancy),
  .out_last  (out_o.last)
);
